// ----- design/pfcd_pkg.sv -----
// Package for the PCM ring FIFO with chunk drain.
// Holds ring sizing, chunk limits, register map and shared types; no dependencies.
package pfcd_pkg;

	localparam int RING_DEPTH = 65536;
	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int PTR_W = IDX_W + 1;
	localparam int POS_W = 12;
	localparam int LEN_W = 13;
	localparam int SMP_W = 16;
	localparam int CNT_W = 17;
	localparam int PADDR_W = 3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [SMP_W-1:0] smp_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam ptr_t DEPTH_PTR = PTR_W'(RING_DEPTH);
	localparam len_t CHUNK_MIN = LEN_W'(128);
	localparam len_t CHUNK_MAX = LEN_W'(4096);
	localparam len_t CHUNK_RESET = LEN_W'(2048);

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_PULL = 1'b1;

	localparam logic [0:0] REG_CHUNK_LENGTH = 1'b0;

endpackage

// ----- design/pfcd_sample_ram.sv -----
// Sample store of the ring FIFO: one write port, one registered read port.
// Depends on pfcd_pkg for depth and sample width.
module pfcd_sample_ram (
	input  logic           clk,
	input  logic           we,
	input  pfcd_pkg::idx_t waddr,
	input  pfcd_pkg::smp_t wdata,
	input  logic           re,
	input  pfcd_pkg::idx_t raddr,
	output pfcd_pkg::smp_t rdata
);
	import pfcd_pkg::*;

	smp_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/pcm_ring_fifo_chunk_drain_core.sv -----
// Top level of the PCM ring FIFO with burst admission and fixed-length chunk drain.
// Depends on pfcd_pkg and pfcd_sample_ram.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  tdata: sample, submit_count; tuser: req_type
//   m_*      out  m_tvalid / m_tready  tdata: out_sample; tlast: chunk_last; tuser: padded, dropped
//   apb      in   psel / penable       chunk_length at byte address 0
//
// An item is accepted every cycle while s_tready is high; its result is registered in the
// read port of the sample store and then in the output register before it is presented.
// Reset clears cursors, burst and chunk state; the sample store is not cleared.
// A stalled output holds its item and at most one more item waits in the read stage.
module pcm_ring_fifo_chunk_drain_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [39:0]               s_tdata,  // sample[15:0], submit_count[32:16], zeros
	input  logic                      s_tuser,  // req_type
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,  // out_sample[15:0]
	output logic                      m_tlast,
	output logic [1:0]                m_tuser,  // padded[0], dropped[1]
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [pfcd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import pfcd_pkg::*;

	ptr_t wc_q, wp_q, rc_q;
	cnt_t brem_q;
	logic bacc_q;
	pos_t cpos_q;
	len_t ctake_q;
	len_t clen_q;

	logic valid_s1, pull_s1, last_s1, pad_s1, drop_s1;
	logic out_valid_q, out_last_q, out_pad_q, out_drop_q;
	smp_t out_sample_q;

	logic accept, out_free, advance;
	logic req;
	smp_t smp;
	cnt_t count;

	logic opening, acc_new, acc_eff, mem_we, mem_re;
	cnt_t brem_eff, brem_next;
	ptr_t used, free_space, wp_eff, wp_inc;

	len_t len, take_eff, done, adv;
	ptr_t vis;
	logic pad, last;
	idx_t raddr;
	smp_t rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHUNK_LENGTH) ? {{(32-LEN_W){1'b0}}, clen_q} : 32'd0;

	assign req = s_tuser;
	assign smp = s_tdata[15:0];
	assign count = s_tdata[32:16];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept = s_tvalid && s_tready;
	assign advance = valid_s1 && out_free;

	always_comb begin
		opening = (brem_q == '0);
		used = wc_q - rc_q;
		free_space = DEPTH_PTR - used;
		acc_new = ({1'b0, count} <= {1'b0, free_space});
		brem_eff = opening ? count : brem_q;
		acc_eff = opening ? acc_new : bacc_q;
		wp_eff = opening ? wc_q : wp_q;
		wp_inc = wp_eff + PTR_W'(1);
		brem_next = brem_eff - CNT_W'(1);
		mem_we = accept && (req == REQ_PUSH) && (brem_eff != '0) && acc_eff;

		len = clen_q;
		if (clen_q < CHUNK_MIN) begin
			len = CHUNK_MIN;
		end else if (clen_q > CHUNK_MAX) begin
			len = CHUNK_MAX;
		end
		vis = wc_q - rc_q;
		if (cpos_q == '0) begin
			take_eff = (vis < PTR_W'(len)) ? LEN_W'(vis) : len;
		end else begin
			take_eff = ctake_q;
		end
		pad = !(LEN_W'(cpos_q) < take_eff);
		done = LEN_W'(cpos_q) + LEN_W'(1);
		last = (done >= len);
		adv = (take_eff < done) ? take_eff : done;
		raddr = IDX_W'(rc_q + PTR_W'(cpos_q));
		mem_re = accept && (req == REQ_PULL);
	end

	pfcd_sample_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (IDX_W'(wp_eff)),
		.wdata (smp),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clen_q <= CHUNK_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHUNK_LENGTH) begin
			clen_q <= pwdata[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
			wp_q <= '0;
			rc_q <= '0;
			brem_q <= '0;
			bacc_q <= 1'b0;
			cpos_q <= '0;
			ctake_q <= '0;
		end else if (accept) begin
			if (req == REQ_PUSH) begin
				if (brem_eff != '0) begin
					brem_q <= brem_next;
					if (acc_eff) begin
						wp_q <= wp_inc;
					end else begin
						wp_q <= wp_eff;
					end
					if (brem_next == '0) begin
						if (acc_eff) begin
							wc_q <= wp_inc;
						end
						bacc_q <= 1'b0;
					end else begin
						bacc_q <= acc_eff;
					end
				end
			end else begin
				ctake_q <= take_eff;
				if (last) begin
					rc_q <= rc_q + PTR_W'(adv);
					cpos_q <= '0;
				end else begin
					cpos_q <= POS_W'(done);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pull_s1 <= (req == REQ_PULL);
			last_s1 <= (req == REQ_PULL) && last;
			pad_s1 <= (req == REQ_PULL) && pad;
			drop_s1 <= (req == REQ_PUSH) && ((brem_eff == '0) || !acc_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= (pull_s1 && !pad_s1) ? rdata : '0;
			out_last_q <= last_s1;
			out_pad_q <= pad_s1;
			out_drop_q <= drop_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_sample_q;
	assign m_tlast = out_last_q;
	assign m_tuser = {out_drop_q, out_pad_q};

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled while a pipeline slot is free");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("padded and dropped set on one item");

	a_last_pull: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tuser[1])
		else $error("chunk end flagged on a push");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(wc_q - rc_q) <= DEPTH_PTR)
		else $error("committed occupancy exceeds ring depth");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pcm_ring_fifo_chunk_drain_core: bursts of pushes and chunk pulls
// are streamed in; each output is checked against an in-bench ring predictor or a typed result.
// Depends on pfcd_pkg and the RTL of the core.
module tb;
	import pfcd_pkg::*;

	typedef struct packed {
		smp_t out_sample;
		logic chunk_last;
		logic padded;
		logic dropped;
	} pcm_result_t;

	typedef enum {ROW_ITEM, ROW_PULLS, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        req;
		smp_t        smp;
		cnt_t        cnt;
		int          reps;
		bit          typed;
		pcm_result_t res;
		logic [31:0] wval;
	} stim_row_t;

	localparam pcm_result_t QUIET = '{16'h0000, 1'b0, 1'b0, 1'b0};
	localparam pcm_result_t PAD = '{16'h0000, 1'b0, 1'b1, 1'b0};
	localparam pcm_result_t DROP = '{16'h0000, 1'b0, 1'b0, 1'b1};
	localparam int N_ROWS = 23;
	localparam int N_PHASES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	smp_t ring [RING_DEPTH];
	ptr_t wr_commit, wr_pend, rd_commit;
	cnt_t burst_left;
	logic burst_ok;
	pos_t chunk_pos;
	len_t chunk_take;
	len_t chunk_len;

	pcm_result_t pending_results [$];
	int n_mismatch = 0;
	int n_push = 0, n_pull = 0, n_drop = 0, n_pad = 0, n_chunks = 0, n_settings = 0;
	int idle_pct = 11;
	int hold_left = 0;
	int hold_reqs = 0;
	int hold_seen = 0;

	stim_row_t dir_rows [N_ROWS] = '{
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b1, PAD, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'h1234, 17'd0, 0, 1'b1, DROP, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'h7FFF, 17'd1, 0, 1'b1, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'h8000, 17'd3, 0, 1'b1, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'hFFFF, 17'h1FFFF, 0, 1'b1, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'h0001, 17'd0, 0, 1'b1, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'hFFFF, 17'h1FFFF, 0, 1'b1, PAD, 32'd0},
		'{ROW_CFG, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_PULLS, REQ_PULL, 16'h0000, 17'd0, 126, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_CFG, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'hDEAD_1FFF},
		'{ROW_ITEM, REQ_PUSH, 16'h00FF, 17'd2, 0, 1'b1, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'hFF00, 17'd0, 0, 1'b1, QUIET, 32'd0},
		'{ROW_PULLS, REQ_PULL, 16'h0000, 17'd0, 200, 1'b0, QUIET, 32'd0},
		'{ROW_CFG, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd128},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd0},
		'{ROW_ITEM, REQ_PUSH, 16'h4321, 17'd1, 0, 1'b1, QUIET, 32'd0},
		'{ROW_CFG, REQ_PULL, 16'h0000, 17'd0, 0, 1'b0, QUIET, 32'd4097}
	};

	logic [31:0] phase_len [N_PHASES] = '{32'd128, 32'd4096, 32'd0, 32'd300,
		32'hDEAD_1001, 32'd129, 32'd8191, 32'd2048};
	int phase_pull_pct [N_PHASES] = '{50, 40, 60, 55, 45, 70, 50, 50};

	pcm_ring_fifo_chunk_drain_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pcm_result_t next_pcm_result(input logic req, input smp_t smp,
			input cnt_t cnt);
		pcm_result_t r;
		int unsigned room, len, vis, done, adv;
		r = QUIET;
		if (req == REQ_PUSH) begin
			if (burst_left == 0) begin
				if (cnt == 0) begin
					r.dropped = 1'b1;
				end else begin
					room = RING_DEPTH - int'(ptr_t'(wr_commit - rd_commit));
					burst_left = cnt;
					burst_ok = (cnt <= room);
					wr_pend = wr_commit;
				end
			end
			if (burst_left != 0) begin
				if (burst_ok) begin
					ring[idx_t'(wr_pend)] = smp;
					wr_pend = wr_pend + 1'b1;
				end else begin
					r.dropped = 1'b1;
				end
				burst_left = burst_left - 1'b1;
				if (burst_left == 0) begin
					if (burst_ok)
						wr_commit = wr_pend;
					burst_ok = 1'b0;
				end
			end
		end else begin
			len = chunk_len;
			if (len < CHUNK_MIN)
				len = CHUNK_MIN;
			if (len > CHUNK_MAX)
				len = CHUNK_MAX;
			if (chunk_pos == 0) begin
				vis = ptr_t'(wr_commit - rd_commit);
				chunk_take = len_t'((vis < len) ? vis : len);
			end
			if (chunk_pos < chunk_take)
				r.out_sample = ring[idx_t'(rd_commit + ptr_t'(chunk_pos))];
			else
				r.padded = 1'b1;
			done = int'(chunk_pos) + 1;
			if (done >= len) begin
				adv = (chunk_take < done) ? chunk_take : done;
				rd_commit = rd_commit + ptr_t'(adv);
				chunk_pos = '0;
				r.chunk_last = 1'b1;
			end else begin
				chunk_pos = pos_t'(done);
			end
		end
		return r;
	endfunction

	function automatic smp_t rand_sample();
		smp_t edges [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		if ($urandom_range(99) < 10)
			return edges[$urandom_range(3)];
		return smp_t'($urandom);
	endfunction

	task automatic send_item(input logic req, input smp_t smp, input cnt_t cnt,
			input bit typed, input pcm_result_t typed_res);
		pcm_result_t r;
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {7'd0, cnt, smp};
		do @(posedge clk); while (!s_tready);
		r = next_pcm_result(req, smp, cnt);
		pending_results.push_back(typed ? typed_res : r);
		if (req == REQ_PUSH) begin
			n_push++;
			n_drop += r.dropped;
		end else begin
			n_pull++;
			n_pad += r.padded;
			n_chunks += r.chunk_last;
		end
	endtask

	task automatic push_sample(input smp_t smp, input cnt_t cnt);
		send_item(REQ_PUSH, smp, cnt, 1'b0, QUIET);
	endtask

	task automatic pull_sample();
		send_item(REQ_PULL, smp_t'($urandom), cnt_t'($urandom), 1'b0, QUIET);
	endtask

	task automatic push_run(input int n, input cnt_t first_cnt);
		push_sample(rand_sample(), first_cnt);
		for (int i = 1; i < n; i++)
			push_sample(rand_sample(), cnt_t'($urandom));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_chunk_length(input logic [31:0] value);
		wait_idle();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'({REG_CHUNK_LENGTH, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		chunk_len = len_t'(value);
		n_settings++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic run_random(input int n, input int pull_pct, input bit with_hold,
			input bit with_pause);
		int r;
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == n / 4)
				hold_reqs++;
			if (with_pause && i == n / 2)
				wait_idle();
			r = $urandom_range(99);
			if (r < pull_pct) begin
				pull_sample();
			end else if (burst_left != 0) begin
				push_sample(rand_sample(), cnt_t'($urandom));
			end else if (r < pull_pct + 3) begin
				push_sample(rand_sample(), '0);
			end else if ($urandom_range(99) < 85) begin
				push_sample(rand_sample(), cnt_t'($urandom_range(1, 48)));
			end else begin
				push_sample(rand_sample(), cnt_t'($urandom_range(1, 700)));
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = !(idle_pct != 0 && $urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		pcm_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
			if (pending_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected output item: sample %h last %b pad %b drop %b",
						got.out_sample, got.chunk_last, got.padded, got.dropped);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"mismatch: expected sample %h last %b pad %b drop %b,",
							" got sample %h last %b pad %b drop %b"},
							want.out_sample, want.chunk_last, want.padded, want.dropped,
							got.out_sample, got.chunk_last, got.padded, got.dropped);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_PUSH;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		wr_commit = '0;
		wr_pend = '0;
		rd_commit = '0;
		burst_left = '0;
		burst_ok = 1'b0;
		chunk_pos = '0;
		chunk_take = '0;
		chunk_len = CHUNK_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_ITEM: begin
					send_item(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].cnt,
						dir_rows[i].typed, dir_rows[i].res);
				end
				ROW_PULLS: begin
					repeat (dir_rows[i].reps) pull_sample();
				end
				default: begin
					set_chunk_length(dir_rows[i].wval);
				end
			endcase
		end

		for (int p = 0; p < N_PHASES; p++) begin
			set_chunk_length(phase_len[p]);
			idle_pct = (p == 1) ? 0 : 11;
			run_random(100, phase_pull_pct[p], p == 2, p == 3);
		end
		idle_pct = 11;

		// Close any open burst, then show that a burst refused for lack of free space
		// stays refused after a chunk frees space.
		set_chunk_length(32'd128);
		while (burst_left != 0)
			push_sample(rand_sample(), cnt_t'($urandom));
		push_run(4, cnt_t'(4));
		push_sample(rand_sample(), cnt_t'(RING_DEPTH));
		do pull_sample(); while (chunk_pos != 0);
		push_run(3, cnt_t'($urandom));
		repeat (4) pull_sample();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d pushes (%0d dropped) and %0d pulls (%0d padded, %0d chunks).",
			n_push, n_drop, n_pull, n_pad, n_chunks);
		$display("Chunk length was written %0d times, including out-of-range values.",
			n_settings);
		if (n_mismatch == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ----- pcm_ring_fifo_chunk_drain_core.f -----
design/pfcd_pkg.sv
design/pfcd_sample_ram.sv
design/pcm_ring_fifo_chunk_drain_core.sv
bench/tb.sv
